/* rtl/core/wmc_pkg.sv */
package wmc_pkg;

  localparam int unsigned LevelW  = 6;
  localparam int unsigned HoldW   = 5;
  localparam int unsigned SecW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 6;

  localparam logic [1:0] FUNC_BUTTON = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_FULL_LEVEL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_STEPS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_SECONDS = 2'd2;

  localparam logic [LevelW-1:0] FULL_LEVEL_RST   = 6'd40;
  localparam logic [HoldW-1:0]  HOLD_STEPS_RST   = 5'd20;
  localparam logic [SecW-1:0]   AUTO_SECONDS_RST = 3'd6;
  localparam logic [SecW-1:0]   SEC_MAX          = 3'd7;

  typedef enum logic [2:0] {
    CMD_STOP    = 3'd0,
    CMD_OPEN_R  = 3'd1,
    CMD_CLOSE_R = 3'd2,
    CMD_OPEN_L  = 3'd3,
    CMD_CLOSE_L = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] buttons;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        motor_drive;
    logic [LevelW-1:0] right_level;
    logic [LevelW-1:0] left_level;
    logic              right_auto;
    logic              left_auto;
    logic [2:0]        active_command;
  } out_word_t;

  typedef struct packed {
    logic [LevelW-1:0] count;
    logic [HoldW-1:0]  hold;
    logic              auto_f;
    logic [SecW-1:0]   secs;
  } side_state_t;

  typedef struct packed {
    logic move;
    logic opening;
    logic stop;
    logic tick;
  } side_ctl_t;

  typedef struct packed {
    logic [LevelW-1:0] full_level;
    logic [HoldW-1:0]  hold_steps;
    logic [SecW-1:0]   auto_seconds;
  } cfg_t;

endpackage

/* rtl/core/wmc_side.sv */
module wmc_side (
  input  wmc_pkg::side_ctl_t   ctl,
  input  wmc_pkg::cfg_t        cfg,
  input  wmc_pkg::side_state_t st,
  input  logic [1:0]           pins,
  output wmc_pkg::side_state_t st_nxt,
  output logic [1:0]           pins_nxt
);

  logic [wmc_pkg::HoldW-1:0] hold_inc;
  logic [wmc_pkg::SecW-1:0]  secs_inc;

  always_comb begin
    st_nxt   = st;
    pins_nxt = pins;
    hold_inc = st.hold + wmc_pkg::HoldW'(1);
    secs_inc = (st.secs < wmc_pkg::SEC_MAX) ? st.secs + wmc_pkg::SecW'(1) : st.secs;
    if (ctl.move) begin
      if (ctl.opening) begin
        if (st.count < cfg.full_level) begin
          pins_nxt     = 2'b01;
          st_nxt.count = st.count + wmc_pkg::LevelW'(1);
        end else if (st.count > cfg.full_level) begin
          st_nxt.count = cfg.full_level;
        end
      end else if (st.count != '0) begin
        pins_nxt     = 2'b10;
        st_nxt.count = st.count - wmc_pkg::LevelW'(1);
      end
      st_nxt.hold = hold_inc;
      if (hold_inc == cfg.hold_steps) begin
        st_nxt.auto_f = 1'b1;
        st_nxt.secs   = '0;
        st_nxt.hold   = '0;
        st_nxt.count  = ctl.opening ? cfg.full_level : '0;
      end
    end else if (ctl.stop) begin
      if (!st.auto_f) begin
        pins_nxt    = 2'b00;
        st_nxt.hold = '0;
      end
    end else if (ctl.tick) begin
      st_nxt.secs = secs_inc;
      if (st.auto_f && (secs_inc > cfg.auto_seconds)) begin
        st_nxt.auto_f = 1'b0;
      end
    end
  end

endmodule

/* rtl/core/two_window_motor_controller.sv */
// A result word is registered when its input word is accepted and appears in the next cycle.
// Throughput: one word per cycle while out_ready is high; all state updates in one pass.
// A waiting result holds off input; a word enters in the cycle the previous result leaves.
// Reset (rst_n low, synchronous): command stop, levels closed, counts and auto
// flags cleared, motors off, registers back to full 40, hold 20, seconds 6.
module two_window_motor_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wmc_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wmc_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wmc_pkg::CfgW-1:0]      cfg_data
);

  wmc_pkg::cfg_t        cfg_r;
  wmc_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [3:0]           pins_r, pins_nxt;
  wmc_pkg::side_state_t rside_r, rside_nxt, lside_r, lside_nxt;
  wmc_pkg::side_ctl_t   rctl, lctl;
  wmc_pkg::out_word_t   out_data_r, out_data_nxt;
  logic                 out_valid_r;
  logic                 in_fire;
  logic                 is_step;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_step   = (in_data.func == wmc_pkg::FUNC_STEP);

  always_comb begin
    cmd_nxt = cmd_r;
    if (in_data.func == wmc_pkg::FUNC_BUTTON) begin
      if (!in_data.buttons[1]) begin
        cmd_nxt = wmc_pkg::CMD_OPEN_R;
      end else if (!in_data.buttons[0]) begin
        cmd_nxt = wmc_pkg::CMD_CLOSE_R;
      end else if (!in_data.buttons[2]) begin
        cmd_nxt = wmc_pkg::CMD_CLOSE_L;
      end else if (!in_data.buttons[3]) begin
        cmd_nxt = wmc_pkg::CMD_OPEN_L;
      end else begin
        cmd_nxt = wmc_pkg::CMD_STOP;
      end
    end
  end

  always_comb begin
    rctl.move    = is_step && (cmd_r == wmc_pkg::CMD_OPEN_R || cmd_r == wmc_pkg::CMD_CLOSE_R);
    rctl.opening = (cmd_r == wmc_pkg::CMD_OPEN_R);
    rctl.stop    = is_step && (cmd_r == wmc_pkg::CMD_STOP);
    rctl.tick    = (in_data.func == wmc_pkg::FUNC_TICK);
    lctl.move    = is_step && (cmd_r == wmc_pkg::CMD_OPEN_L || cmd_r == wmc_pkg::CMD_CLOSE_L);
    lctl.opening = (cmd_r == wmc_pkg::CMD_OPEN_L);
    lctl.stop    = rctl.stop;
    lctl.tick    = rctl.tick;
  end

  wmc_side u_right (
    .ctl      (rctl),
    .cfg      (cfg_r),
    .st       (rside_r),
    .pins     (pins_r[1:0]),
    .st_nxt   (rside_nxt),
    .pins_nxt (pins_nxt[1:0])
  );

  wmc_side u_left (
    .ctl      (lctl),
    .cfg      (cfg_r),
    .st       (lside_r),
    .pins     (pins_r[3:2]),
    .st_nxt   (lside_nxt),
    .pins_nxt (pins_nxt[3:2])
  );

  always_comb begin
    out_data_nxt.motor_drive    = pins_nxt;
    out_data_nxt.right_level    = rside_nxt.count;
    out_data_nxt.left_level     = lside_nxt.count;
    out_data_nxt.right_auto     = rside_nxt.auto_f;
    out_data_nxt.left_auto      = lside_nxt.auto_f;
    out_data_nxt.active_command = cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_level   <= wmc_pkg::FULL_LEVEL_RST;
      cfg_r.hold_steps   <= wmc_pkg::HOLD_STEPS_RST;
      cfg_r.auto_seconds <= wmc_pkg::AUTO_SECONDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmc_pkg::CFG_FULL_LEVEL:   cfg_r.full_level   <= cfg_data[wmc_pkg::LevelW-1:0];
        wmc_pkg::CFG_HOLD_STEPS:   cfg_r.hold_steps   <= cfg_data[wmc_pkg::HoldW-1:0];
        wmc_pkg::CFG_AUTO_SECONDS: cfg_r.auto_seconds <= cfg_data[wmc_pkg::SecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= wmc_pkg::CMD_STOP;
      pins_r      <= '0;
      rside_r     <= '0;
      lside_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cmd_r       <= cmd_nxt;
        pins_r      <= pins_nxt;
        rside_r     <= rside_nxt;
        lside_r     <= lside_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(pins_r[0] && pins_r[1]) && !(pins_r[2] && pins_r[3]))
    else $error("motor driven both ways");

  a_stop_clears_right: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_step && cmd_r == wmc_pkg::CMD_STOP && !rside_r.auto_f
    |=> out_data_r.motor_drive[1:0] == 2'b00 && rside_r.hold == '0)
    else $error("stop left right motor running");

  a_tick_no_auto: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.func == wmc_pkg::FUNC_TICK && !rside_r.auto_f && !lside_r.auto_f
    |=> !rside_r.auto_f && !lside_r.auto_f)
    else $error("tick engaged auto mode");

endmodule

/* bench/two_window_motor_controller_tb.sv */
module two_window_motor_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  wmc_pkg::in_word_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  wmc_pkg::out_word_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [wmc_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [wmc_pkg::CfgW-1:0]      cfg_data  = '0;

  two_window_motor_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // window state as the controller should hold it; index 0 right, 1 left
  wmc_pkg::side_state_t       win [2];
  logic [3:0]                 pins;
  wmc_pkg::cmd_t              cmd_reg;
  logic [wmc_pkg::LevelW-1:0] full_cfg;
  logic [wmc_pkg::HoldW-1:0]  hold_cfg;
  logic [wmc_pkg::SecW-1:0]   auto_cfg;

  wmc_pkg::in_word_t  pending_events [$];
  wmc_pkg::out_word_t expected_status [$];
  int        fail_count   = 0;
  int        sender_max   = 0;
  int        receiver_max = 0;
  int        gap          = 0;
  int        stall        = 0;
  int        stalled_cycles = 0;

  function automatic void move_window(int sd, bit opening);
    logic [3:0] open_b, close_b;
    open_b  = 4'b0001 << (2 * sd);
    close_b = 4'b0010 << (2 * sd);
    if (opening) begin
      if (win[sd].count < full_cfg) begin
        pins = (pins | open_b) & ~close_b;
        win[sd].count = win[sd].count + wmc_pkg::LevelW'(1);
      end else if (win[sd].count > full_cfg) begin
        win[sd].count = full_cfg;
      end
    end else if (win[sd].count != '0) begin
      win[sd].count = win[sd].count - wmc_pkg::LevelW'(1);
      pins = (pins | close_b) & ~open_b;
    end
    win[sd].hold = win[sd].hold + wmc_pkg::HoldW'(1);
    if (win[sd].hold == hold_cfg) begin
      win[sd].auto_f = 1'b1;
      win[sd].secs   = '0;
      win[sd].hold   = '0;
      win[sd].count  = opening ? full_cfg : '0;
    end
  endfunction

  function automatic wmc_pkg::out_word_t predict_status(wmc_pkg::in_word_t w);
    wmc_pkg::out_word_t s;
    case (w.func)
      wmc_pkg::FUNC_BUTTON: begin
        if (!w.buttons[1])      cmd_reg = wmc_pkg::CMD_OPEN_R;
        else if (!w.buttons[0]) cmd_reg = wmc_pkg::CMD_CLOSE_R;
        else if (!w.buttons[2]) cmd_reg = wmc_pkg::CMD_CLOSE_L;
        else if (!w.buttons[3]) cmd_reg = wmc_pkg::CMD_OPEN_L;
        else                    cmd_reg = wmc_pkg::CMD_STOP;
      end
      wmc_pkg::FUNC_STEP: begin
        case (cmd_reg)
          wmc_pkg::CMD_OPEN_R:  move_window(0, 1'b1);
          wmc_pkg::CMD_CLOSE_R: move_window(0, 1'b0);
          wmc_pkg::CMD_OPEN_L:  move_window(1, 1'b1);
          wmc_pkg::CMD_CLOSE_L: move_window(1, 1'b0);
          default: begin
            for (int sd = 0; sd < 2; sd++) begin
              if (!win[sd].auto_f) begin
                pins &= ~(4'b0011 << (2 * sd));
                win[sd].hold = '0;
              end
            end
          end
        endcase
      end
      wmc_pkg::FUNC_TICK: begin
        for (int sd = 0; sd < 2; sd++) begin
          if (win[sd].secs < wmc_pkg::SEC_MAX) begin
            win[sd].secs = win[sd].secs + wmc_pkg::SecW'(1);
          end
          if (win[sd].auto_f && win[sd].secs > auto_cfg) win[sd].auto_f = 1'b0;
        end
      end
      default: ;
    endcase
    s.motor_drive    = pins;
    s.right_level    = win[0].count;
    s.left_level     = win[1].count;
    s.right_auto     = win[0].auto_f;
    s.left_auto      = win[1].auto_f;
    s.active_command = cmd_reg;
    return s;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap      <= 0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(predict_status(in_data));
      if (!in_valid || in_ready) begin
        if (gap != 0) begin
          gap      <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          in_data  <= pending_events.pop_front();
          in_valid <= 1'b1;
          gap      <= $urandom_range(0, sender_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    wmc_pkg::out_word_t want;
    int                 d;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall     <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("result word with no expectation: %h", out_data);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("motor_drive", 8'(want.motor_drive), 8'(out_data.motor_drive));
        check_field("right_level", 8'(want.right_level), 8'(out_data.right_level));
        check_field("left_level", 8'(want.left_level), 8'(out_data.left_level));
        check_field("right_auto", 8'(want.right_auto), 8'(out_data.right_auto));
        check_field("left_auto", 8'(want.left_auto), 8'(out_data.left_auto));
        check_field("active_command", 8'(want.active_command),
                    8'(out_data.active_command));
      end
      d = $urandom_range(0, receiver_max);
      stall     <= d;
      out_ready <= (d == 0);
    end else if (stall != 0) begin
      stall     <= stall - 1;
      out_ready <= (stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic write_reg(logic [wmc_pkg::CfgIdxW-1:0] idx,
                           logic [wmc_pkg::CfgW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      wmc_pkg::CFG_FULL_LEVEL:   full_cfg = value[wmc_pkg::LevelW-1:0];
      wmc_pkg::CFG_HOLD_STEPS:   hold_cfg = value[wmc_pkg::HoldW-1:0];
      wmc_pkg::CFG_AUTO_SECONDS: auto_cfg = value[wmc_pkg::SecW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  task automatic queue_event(logic [1:0] func, logic [3:0] buttons);
    wmc_pkg::in_word_t w;
    w.func    = func;
    w.buttons = buttons;
    pending_events.push_back(w);
  endtask

  // mostly press, hold for a run of steps, sometimes release, let seconds pass
  task automatic queue_random_events(int count);
    int made;
    int run;
    logic [3:0] press;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        made++;
      end else begin
        press = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : ~(4'b0001 << $urandom_range(0, 3));
        queue_event(wmc_pkg::FUNC_BUTTON, press);
        run = $urandom_range(1, 40);
        repeat (run) begin
          if ($urandom_range(0, 19) == 0) begin
            queue_event(wmc_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
          end
          queue_event(wmc_pkg::FUNC_STEP, 4'($urandom_range(0, 15)));
        end
        made += run + 1;
        if ($urandom_range(0, 1) == 1) begin
          queue_event(wmc_pkg::FUNC_BUTTON, 4'b1111);
          run = $urandom_range(1, 3);
          repeat (run) queue_event(wmc_pkg::FUNC_STEP, 4'($urandom_range(0, 15)));
          made += run + 1;
        end
        run = $urandom_range(0, 9);
        repeat (run) queue_event(wmc_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
        made += run;
      end
    end
  endtask

  task automatic run_phase(logic [5:0] full, logic [4:0] hold, logic [2:0] secs,
                           int count);
    write_reg(wmc_pkg::CFG_FULL_LEVEL, full);
    write_reg(wmc_pkg::CFG_HOLD_STEPS, wmc_pkg::CfgW'(hold));
    write_reg(wmc_pkg::CFG_AUTO_SECONDS, wmc_pkg::CfgW'(secs));
    @(negedge clk);
    sender_max   = ($urandom_range(0, 2) == 0) ? 0 : 7;
    receiver_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
    queue_random_events(count);
    drain();
  endtask

  initial begin : stimulus
    wmc_pkg::in_word_t plan [24];
    plan = '{
      {wmc_pkg::FUNC_NONE, 4'b0000},   {wmc_pkg::FUNC_BUTTON, 4'b1101},
      {wmc_pkg::FUNC_STEP, 4'b0000},   {wmc_pkg::FUNC_STEP, 4'b1111},
      {wmc_pkg::FUNC_BUTTON, 4'b1110}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_STEP, 4'b0000},   {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b1011}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b0111}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b1111}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b0000}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b1100}, {wmc_pkg::FUNC_TICK, 4'b0000},
      {wmc_pkg::FUNC_TICK, 4'b1111},   {wmc_pkg::FUNC_NONE, 4'b1111},
      {wmc_pkg::FUNC_BUTTON, 4'b0110}, {wmc_pkg::FUNC_STEP, 4'b0000},
      {wmc_pkg::FUNC_BUTTON, 4'b1111}, {wmc_pkg::FUNC_STEP, 4'b0000}
    };
    full_cfg = wmc_pkg::FULL_LEVEL_RST;
    hold_cfg = wmc_pkg::HOLD_STEPS_RST;
    auto_cfg = wmc_pkg::AUTO_SECONDS_RST;
    cmd_reg  = wmc_pkg::CMD_STOP;
    pins     = '0;
    win[0]   = '0;
    win[1]   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i]) pending_events.push_back(plan[i]);
    drain();

    @(negedge clk);
    sender_max   = 7;
    receiver_max = 7;
    queue_random_events(300);
    drain();

    run_phase(6'd63, 5'd31, 3'd6, 250);
    run_phase(6'd1, 5'd1, 3'd0, 200);
    run_phase(6'd0, 5'd0, 3'd7, 150);
    repeat (3) begin
      run_phase(6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                3'($urandom_range(0, 7)), 200);
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/wmc_pkg.sv
rtl/core/wmc_side.sv
rtl/core/two_window_motor_controller.sv
bench/two_window_motor_controller_tb.sv
